/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is active.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/tcs_pkg.sv */
// ----------------------------------------------------------------------------
// tcs_pkg
// Types and codes for the thermal cycler sequencer.
// ----------------------------------------------------------------------------
package tcs_pkg;

    localparam int TEMP_W  = 7;
    localparam int COUNT_W = 8;
    localparam int STAGE_W = 3;
    localparam int ACT_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    typedef logic [TEMP_W-1:0]  temp_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [STAGE_W-1:0] stage_t;
    typedef logic [ACT_W-1:0]   action_t;

    // Stage codes
    localparam stage_t STAGE_INITIAL  = 3'd0;
    localparam stage_t STAGE_DENATURE = 3'd1;
    localparam stage_t STAGE_ANNEAL   = 3'd2;
    localparam stage_t STAGE_EXTEND   = 3'd3;
    localparam stage_t STAGE_FINAL    = 3'd4;

    // Action codes
    localparam action_t ACT_HEAT = 2'd0;
    localparam action_t ACT_COOL = 2'd1;
    localparam action_t ACT_HOLD = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DENATURE_TEMP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANNEAL_TEMP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXTEND_TEMP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FINAL_TEMP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DENATURE_HOLD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ANNEAL_HOLD   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EXTEND_HOLD   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_TOTAL   = 3'd7;

    // Register reset values
    localparam temp_t  RST_DENATURE_TEMP = 7'd94;
    localparam temp_t  RST_ANNEAL_TEMP   = 7'd55;
    localparam temp_t  RST_EXTEND_TEMP   = 7'd72;
    localparam temp_t  RST_FINAL_TEMP    = 7'd4;
    localparam count_t RST_DENATURE_HOLD = 8'd7;
    localparam count_t RST_ANNEAL_HOLD   = 8'd10;
    localparam count_t RST_EXTEND_HOLD   = 8'd8;
    localparam count_t RST_CYCLE_TOTAL   = 8'd3;

    localparam count_t CYCLE_FIRST = 8'd1;
    localparam count_t CYCLE_MAX   = 8'd255;

endpackage

/* src/thermal_cycler_sequencer.sv */
// ----------------------------------------------------------------------------
// thermal_cycler_sequencer
// Tick-driven setpoint sequencer: ramps toward each stage target, holds,
// and steps through initial, cycled and final stages.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------
//  in      | in  | in_valid / in_ready  | restart
//  out     | out | out_valid / out_ready| temperature, stage, cycle_index,
//          |     |                      | action, hold_elapsed, finished
//  cfg     | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One tick per clock: the state update and the result are computed in one
//  pass from the accepted beat and the state registers into the result register.
//  The result beat is registered and offered in the cycle after its input beat.
//  A new beat is taken while the result register is empty or being drained.
//  cfg_ready is always high. Reset clears state and loads register defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module thermal_cycler_sequencer
    import tcs_pkg::*;
#(
    parameter int TOLERANCE    = 1,
    parameter int START_TEMP   = 85,
    parameter int INITIAL_HOLD = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // tick input
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  restart,
    // result output
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [TEMP_W-1:0]     temperature,
    output logic [STAGE_W-1:0]    stage,
    output logic [COUNT_W-1:0]    cycle_index,
    output logic [ACT_W-1:0]      action,
    output logic [COUNT_W-1:0]    hold_elapsed,
    output logic                  finished,
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam temp_t  START_T   = temp_t'(START_TEMP);
    localparam count_t INIT_LIM  = count_t'(INITIAL_HOLD);
    localparam logic [TEMP_W+1:0] TOL_X = (TEMP_W+2)'(TOLERANCE);

    // configuration registers
    temp_t  denature_temp_reg, anneal_temp_reg, extend_temp_reg, final_temp_reg;
    count_t denature_hold_reg, anneal_hold_reg, extend_hold_reg, cycle_total_reg;

    // tick state
    temp_t  setpoint_reg, setpoint_next;
    stage_t stage_reg, stage_next;
    count_t cycle_reg, cycle_next;
    count_t hold_reg, hold_next;
    action_t action_next;

    // result register
    logic    out_valid_reg;
    temp_t   temperature_reg;
    stage_t  stage_out_reg;
    count_t  cycle_out_reg;
    action_t action_reg;
    count_t  hold_out_reg;
    logic    finished_reg;

    logic in_beat;
    logic cfg_beat;

    assign cfg_ready = 1'b1;
    assign cfg_beat  = cfg_valid && cfg_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_beat   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            denature_temp_reg <= RST_DENATURE_TEMP;
            anneal_temp_reg   <= RST_ANNEAL_TEMP;
            extend_temp_reg   <= RST_EXTEND_TEMP;
            final_temp_reg    <= RST_FINAL_TEMP;
            denature_hold_reg <= RST_DENATURE_HOLD;
            anneal_hold_reg   <= RST_ANNEAL_HOLD;
            extend_hold_reg   <= RST_EXTEND_HOLD;
            cycle_total_reg   <= RST_CYCLE_TOTAL;
        end
        else if (cfg_beat)
        begin
            unique case (cfg_index)
                REG_DENATURE_TEMP: denature_temp_reg <= cfg_data[TEMP_W-1:0];
                REG_ANNEAL_TEMP:   anneal_temp_reg   <= cfg_data[TEMP_W-1:0];
                REG_EXTEND_TEMP:   extend_temp_reg   <= cfg_data[TEMP_W-1:0];
                REG_FINAL_TEMP:    final_temp_reg    <= cfg_data[TEMP_W-1:0];
                REG_DENATURE_HOLD: denature_hold_reg <= cfg_data;
                REG_ANNEAL_HOLD:   anneal_hold_reg   <= cfg_data;
                REG_EXTEND_HOLD:   extend_hold_reg   <= cfg_data;
                REG_CYCLE_TOTAL:   cycle_total_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // one tick
    always_comb
    begin
        temp_t  target;
        count_t limit;
        logic   endless;
        logic [TEMP_W+1:0]  sp_x;
        logic [TEMP_W+1:0]  tgt_x;
        logic [COUNT_W:0]   count;

        setpoint_next = setpoint_reg;
        stage_next    = stage_reg;
        cycle_next    = cycle_reg;
        hold_next     = hold_reg;
        action_next   = ACT_HOLD;

        unique case (stage_reg)
            STAGE_INITIAL:
            begin
                target = denature_temp_reg; limit = INIT_LIM; endless = 1'b0;
            end
            STAGE_DENATURE:
            begin
                target = denature_temp_reg; limit = denature_hold_reg; endless = 1'b0;
            end
            STAGE_ANNEAL:
            begin
                target = anneal_temp_reg; limit = anneal_hold_reg; endless = 1'b0;
            end
            STAGE_EXTEND:
            begin
                target = extend_temp_reg; limit = extend_hold_reg; endless = 1'b0;
            end
            default:
            begin
                target = final_temp_reg; limit = '0; endless = 1'b1;
            end
        endcase

        sp_x  = {2'b00, setpoint_reg};
        tgt_x = {2'b00, target};
        count = {1'b0, hold_reg} + (COUNT_W+1)'(1);

        if (restart)
        begin
            setpoint_next = START_T;
            stage_next    = STAGE_INITIAL;
            cycle_next    = CYCLE_FIRST;
            hold_next     = '0;
        end
        else if (sp_x + TOL_X <= tgt_x)
        begin
            setpoint_next = setpoint_reg + TEMP_W'(1);
            action_next   = ACT_HEAT;
        end
        else if (sp_x >= tgt_x + TOL_X)
        begin
            setpoint_next = setpoint_reg - TEMP_W'(1);
            action_next   = ACT_COOL;
        end
        else if (!endless)
        begin
            if (count >= {1'b0, limit})
            begin
                hold_next = '0;
                priority if (stage_reg == STAGE_INITIAL)
                    stage_next = (cycle_total_reg == '0) ? STAGE_FINAL : STAGE_DENATURE;
                else if (stage_reg == STAGE_EXTEND)
                begin
                    if (cycle_reg != CYCLE_MAX)
                        cycle_next = cycle_reg + COUNT_W'(1);
                    stage_next = (cycle_reg >= cycle_total_reg) ? STAGE_FINAL
                                                                : STAGE_DENATURE;
                end
                else
                    stage_next = stage_reg + STAGE_W'(1);
            end
            else
                hold_next = count[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg  <= START_T;
            stage_reg     <= STAGE_INITIAL;
            cycle_reg     <= CYCLE_FIRST;
            hold_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_beat)
            begin
                setpoint_reg <= setpoint_next;
                stage_reg    <= stage_next;
                cycle_reg    <= cycle_next;
                hold_reg     <= hold_next;
            end
            if (in_beat)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            temperature_reg <= setpoint_next;
            stage_out_reg   <= stage_next;
            cycle_out_reg   <= cycle_next;
            action_reg      <= action_next;
            hold_out_reg    <= hold_next;
            finished_reg    <= (stage_next >= STAGE_FINAL);
        end
    end

    assign out_valid    = out_valid_reg;
    assign temperature  = temperature_reg;
    assign stage        = stage_out_reg;
    assign cycle_index  = cycle_out_reg;
    assign action       = action_reg;
    assign hold_elapsed = hold_out_reg;
    assign finished     = finished_reg;

    // assertions
    `ASSERT_CLK(a_restart_result, clk, rst_n,
        in_beat && restart |=> out_valid && temperature == START_T
            && stage == STAGE_INITIAL && cycle_index == CYCLE_FIRST && action == ACT_HOLD,
        "restart beat did not give the reset result")
    `ASSERT_CLK(a_finished_match, clk, rst_n,
        out_valid |-> (finished == (stage >= STAGE_FINAL)),
        "finished flag disagrees with stage")
    `ASSERT_CLK(a_final_no_count, clk, rst_n,
        out_valid && finished |-> hold_elapsed == '0,
        "hold count moved during final hold")
    `ASSERT_CLK(a_ready_when_empty, clk, rst_n,
        !out_valid_reg |-> in_ready,
        "input stalled with empty result register")
    `ASSERT_CLK(a_ramp_step, clk, rst_n,
        in_beat && !restart && action_next != ACT_HOLD |=>
            (setpoint_reg == $past(setpoint_reg) + TEMP_W'(1))
            || (setpoint_reg == $past(setpoint_reg) - TEMP_W'(1)),
        "setpoint moved by more than one degree")

endmodule
